// ===== src/jedc_pkg.sv =====
// Shared widths, codes and constants for the joystick event deadzone conditioner.
`timescale 1ns / 1ps

package jedc_pkg;

    // Field widths
    localparam int KIND_W   = 8;
    localparam int INDEX_W  = 8;
    localparam int POS_W    = 16;
    localparam int PULL_W   = 15;
    localparam int BTN_W    = 14;
    localparam int DZ_W     = 15;
    localparam int CFG_IDX_W = 8;

    // Stream payload widths, whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 112;

    // Buttons that an event may address directly
    localparam int BUTTON_COUNT = 14;
    localparam int BTN_IDX_W    = $clog2(BTN_W);

    // Event type codes, init flag stripped
    localparam logic [KIND_W-2:0] KIND_BUTTON = 7'd1;
    localparam logic [KIND_W-2:0] KIND_AXIS   = 7'd2;

    // Axis numbers
    localparam logic [INDEX_W-1:0] AXIS_LEFT_X     = 8'd0;
    localparam logic [INDEX_W-1:0] AXIS_LEFT_Y     = 8'd1;
    localparam logic [INDEX_W-1:0] AXIS_LEFT_PULL  = 8'd2;
    localparam logic [INDEX_W-1:0] AXIS_RIGHT_X    = 8'd3;
    localparam logic [INDEX_W-1:0] AXIS_RIGHT_Y    = 8'd4;
    localparam logic [INDEX_W-1:0] AXIS_RIGHT_PULL = 8'd5;
    localparam logic [INDEX_W-1:0] AXIS_DPAD_X     = 8'd6;
    localparam logic [INDEX_W-1:0] AXIS_DPAD_Y     = 8'd7;

    // D-pad bit positions in the button mask
    localparam int DPAD_UP_BIT    = 10;
    localparam int DPAD_DOWN_BIT  = 11;
    localparam int DPAD_LEFT_BIT  = 12;
    localparam int DPAD_RIGHT_BIT = 13;

    localparam logic signed [POS_W-1:0] HALF_SCALE = 16'sd16384;
    localparam logic signed [POS_W-1:0] POS_MIN    = -16'sd32768;
    localparam logic signed [POS_W-1:0] POS_MAX    = 16'sd32767;

    // Unit scale for the rescale divisor (1.0 in Q1.15)
    localparam logic [POS_W-1:0] FULL_SCALE = 16'h8000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DZ   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_DZ = 8'd1;

    localparam logic [DZ_W-1:0] DZ_RESET = 15'd3277;

endpackage

// ===== src/jedc_rescale.sv =====
// Deadzone and rescale unit with a bit-serial restoring divider.
`timescale 1ns / 1ps

module jedc_rescale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [jedc_pkg::POS_W-1:0]   i_value,
    input  logic        [jedc_pkg::DZ_W-1:0]    i_thresh,
    output logic                                o_done,
    output logic signed [jedc_pkg::POS_W-1:0]   o_result
);
    import jedc_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    typedef enum logic {
        RS_IDLE,
        RS_DIV
    } t_rs_state;

    t_rs_state          r_state, n_state;
    logic               r_done, n_done;
    logic               r_neg, n_neg;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [POS_W-1:0]   r_rem, n_rem;
    logic [POS_W-1:0]   r_div, n_div;
    logic [POS_W-1:0]   r_quo, n_quo;
    logic signed [POS_W-1:0] r_result, n_result;

    logic               in_neg;
    logic [POS_W:0]     neg_val;
    logic [POS_W-1:0]   mag;
    logic               below;
    logic [POS_W:0]     trial;
    logic               fits;
    logic [POS_W:0]     trial_sub;
    logic [POS_W-1:0]   quo_next;
    logic [POS_W-1:0]   quo_neg;

    // Magnitude and threshold test of the incoming value
    assign in_neg  = i_value[POS_W-1];
    assign neg_val = (POS_W+1)'(0) - {i_value[POS_W-1], i_value};
    assign mag     = in_neg ? neg_val[POS_W-1:0] : i_value;
    assign below   = mag < {1'b0, i_thresh};

    // One quotient bit per cycle; the first step compares without a shift
    assign trial     = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign fits      = trial >= {1'b0, r_div};
    assign trial_sub = trial - {1'b0, r_div};
    assign quo_next  = {r_quo[POS_W-2:0], fits};
    assign quo_neg   = POS_W'(0) - quo_next;

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_div    = r_div;
        n_quo    = r_quo;
        n_result = r_result;
        unique case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    if (below) begin
                        n_result = '0;
                        n_done   = 1'b1;
                    end else begin
                        n_neg   = in_neg;
                        n_rem   = mag - {1'b0, i_thresh};
                        n_div   = FULL_SCALE - {1'b0, i_thresh};
                        n_cnt   = '0;
                        n_quo   = '0;
                        n_state = RS_DIV;
                    end
                end
            end
            RS_DIV: begin
                n_rem = fits ? trial_sub[POS_W-1:0] : trial[POS_W-1:0];
                n_quo = quo_next;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(POS_W - 1)) begin
                    // Restore sign; positive side saturates
                    if (r_neg) begin
                        n_result = quo_neg;
                    end else if (quo_next[POS_W-1]) begin
                        n_result = POS_MAX;
                    end else begin
                        n_result = quo_next;
                    end
                    n_done  = 1'b1;
                    n_state = RS_IDLE;
                end
            end
            default: n_state = RS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_quo    <= n_quo;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== src/joystick_event_deadzone_conditioner.sv =====
// Top level: joystick event decode, state snapshot and deadzone conditioning.
//
//  Channel  Dir  Beat contents (lowest bits first)
//  s_axis   in   event_kind[7:0], event_index[15:8], event_level[31:16]
//  m_axis   out  button_mask, left_x, left_y, right_x, right_y, left_pull, right_pull
//  cfg      in   i_cfg_index selects stick (0) or trigger (1) deadzone, i_cfg_data
//
// Button, d-pad and ignored events pass S_EXEC, then S_PUB; an axis also waits in
// S_WAIT for zero inside the deadzone or for the bit-serial divider (16 steps).
// The next beat is taken in the cycle after the result loads, not mid-rescale.
// Reset is synchronous, active low; deadzones return to 3277, positions to zero.
// A result held by m_axis_tready stalls the next load; only one more beat is taken.
`timescale 1ns / 1ps

module joystick_event_deadzone_conditioner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // event_kind, event_index, event_level
    input  logic [jedc_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // button_mask, left_x, left_y, right_x, right_y, left_pull, right_pull, pad
    output logic [jedc_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [jedc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jedc_pkg::DZ_W-1:0]            i_cfg_data
);
    import jedc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_PUB
    } t_state;

    t_state                     r_state, n_state;
    logic [KIND_W-2:0]          r_kind, n_kind;
    logic [INDEX_W-1:0]         r_index, n_index;
    logic signed [POS_W-1:0]    r_level, n_level;
    logic [DZ_W-1:0]            r_stick_dz, n_stick_dz;
    logic [DZ_W-1:0]            r_trigger_dz, n_trigger_dz;
    logic [BTN_W-1:0]           r_buttons, n_buttons;
    logic signed [POS_W-1:0]    r_left_x, n_left_x;
    logic signed [POS_W-1:0]    r_left_y, n_left_y;
    logic signed [POS_W-1:0]    r_right_x, n_right_x;
    logic signed [POS_W-1:0]    r_right_y, n_right_y;
    logic [PULL_W-1:0]          r_left_pull, n_left_pull;
    logic [PULL_W-1:0]          r_right_pull, n_right_pull;
    logic                       r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]       r_out_data, n_out_data;

    logic                       s_accept;
    logic                       is_button;
    logic                       is_axis;
    logic                       is_trigger;
    logic                       is_inverted;
    logic                       needs_rescale;
    logic signed [POS_W-1:0]    inv_level;
    logic [PULL_W-1:0]          pull_level;
    logic signed [POS_W-1:0]    rs_value;
    logic [DZ_W-1:0]            rs_thresh;
    logic                       rs_start;
    logic                       rs_done;
    logic signed [POS_W-1:0]    rs_result;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Decode the held event
    assign is_button   = r_kind == KIND_BUTTON;
    assign is_axis     = r_kind == KIND_AXIS;
    assign is_trigger  = (r_index == AXIS_LEFT_PULL) || (r_index == AXIS_RIGHT_PULL);
    assign is_inverted = (r_index == AXIS_LEFT_Y) || (r_index == AXIS_RIGHT_Y);
    assign needs_rescale = is_axis && (r_index < AXIS_DPAD_X);

    // Y inversion saturates; trigger maps (level + 32768) >> 1
    assign inv_level  = (r_level == POS_MIN) ? POS_MAX : -r_level;
    assign pull_level = {~r_level[POS_W-1], r_level[POS_W-2:1]};

    assign rs_value  = is_trigger  ? $signed({1'b0, pull_level}) :
                       is_inverted ? inv_level : r_level;
    assign rs_thresh = is_trigger ? r_trigger_dz : r_stick_dz;
    assign rs_start  = (r_state == S_EXEC) && needs_rescale;

    jedc_rescale u_rescale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rs_start),
        .i_value  (rs_value),
        .i_thresh (rs_thresh),
        .o_done   (rs_done),
        .o_result (rs_result)
    );

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_index      = r_index;
        n_level      = r_level;
        n_stick_dz   = r_stick_dz;
        n_trigger_dz = r_trigger_dz;
        n_buttons    = r_buttons;
        n_left_x     = r_left_x;
        n_left_y     = r_left_y;
        n_right_x    = r_right_x;
        n_right_y    = r_right_y;
        n_left_pull  = r_left_pull;
        n_right_pull = r_right_pull;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        // Configuration writes
        if (i_cfg_we) begin
            if (i_cfg_index == CFG_STICK_DZ) begin
                n_stick_dz = i_cfg_data;
            end else if (i_cfg_index == CFG_TRIGGER_DZ) begin
                n_trigger_dz = i_cfg_data;
            end
        end

        // Drop the result once taken
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_kind  = s_axis_tdata[KIND_W-2:0];
                    n_index = s_axis_tdata[KIND_W+INDEX_W-1:KIND_W];
                    n_level = s_axis_tdata[KIND_W+INDEX_W+POS_W-1:KIND_W+INDEX_W];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_PUB;
                if (is_button) begin
                    if (r_index < INDEX_W'(BUTTON_COUNT) && r_index < INDEX_W'(BTN_W)) begin
                        n_buttons[r_index[BTN_IDX_W-1:0]] = r_level != '0;
                    end
                end else if (is_axis) begin
                    if (needs_rescale) begin
                        n_state = S_WAIT;
                    end else if (r_index == AXIS_DPAD_X) begin
                        n_buttons[DPAD_LEFT_BIT]  = r_level < -HALF_SCALE;
                        n_buttons[DPAD_RIGHT_BIT] = r_level > HALF_SCALE;
                    end else if (r_index == AXIS_DPAD_Y) begin
                        n_buttons[DPAD_UP_BIT]   = r_level < -HALF_SCALE;
                        n_buttons[DPAD_DOWN_BIT] = r_level > HALF_SCALE;
                    end
                end
            end
            S_WAIT: begin
                if (rs_done) begin
                    unique case (r_index)
                        AXIS_LEFT_X:     n_left_x     = rs_result;
                        AXIS_LEFT_Y:     n_left_y     = rs_result;
                        AXIS_LEFT_PULL:  n_left_pull  = rs_result[PULL_W-1:0];
                        AXIS_RIGHT_X:    n_right_x    = rs_result;
                        AXIS_RIGHT_Y:    n_right_y    = rs_result;
                        default:         n_right_pull = rs_result[PULL_W-1:0];
                    endcase
                    n_state = S_PUB;
                end
            end
            S_PUB: begin
                // Load the snapshot when the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_data = {(M_TDATA_W - BTN_W - 4*POS_W - 2*PULL_W)'(0),
                                  r_right_pull, r_left_pull, r_right_y, r_right_x,
                                  r_left_y, r_left_x, r_buttons};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_stick_dz   <= DZ_RESET;
            r_trigger_dz <= DZ_RESET;
            r_buttons    <= '0;
            r_left_x     <= '0;
            r_left_y     <= '0;
            r_right_x    <= '0;
            r_right_y    <= '0;
            r_left_pull  <= '0;
            r_right_pull <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_stick_dz   <= n_stick_dz;
            r_trigger_dz <= n_trigger_dz;
            r_buttons    <= n_buttons;
            r_left_x     <= n_left_x;
            r_left_y     <= n_left_y;
            r_right_x    <= n_right_x;
            r_right_y    <= n_right_y;
            r_left_pull  <= n_left_pull;
            r_right_pull <= n_right_pull;
            r_out_valid  <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_index    <= n_index;
        r_level    <= n_level;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // An accepted beat always moves on to execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_state == S_EXEC)
        else $error("accepted beat did not enter execution");

    // The divider reports only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rs_done |-> r_state == S_WAIT)
        else $error("rescale finished outside wait state");

    // Trigger results are never negative
    a_trigger_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rs_done && is_trigger) |-> !rs_result[POS_W-1])
        else $error("negative trigger result");

    // A pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("pending result lost");
`endif

endmodule
